@@ rtl/tlc_pkg.sv @@
// Package with shared types and constants of the trajectory limit checker.
package tlc_pkg;

    typedef enum logic [2:0] {
        V_VALID = 3'd0,
        V_SPEED = 3'd1,
        V_ACCEL = 3'd2,
        V_CURV  = 3'd3,
        V_JERK  = 3'd4,
        V_LAT   = 3'd5
    } t_verdict;

    localparam logic [2:0] REG_HORIZON  = 3'd0;
    localparam logic [2:0] REG_SPEED_MIN = 3'd1;
    localparam logic [2:0] REG_SPEED_MAX = 3'd2;
    localparam logic [2:0] REG_ACCEL_MIN = 3'd3;
    localparam logic [2:0] REG_ACCEL_MAX = 3'd4;
    localparam logic [2:0] REG_JERK_MIN  = 3'd5;
    localparam logic [2:0] REG_JERK_MAX  = 3'd6;
    localparam logic [2:0] REG_LAT_MAX   = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted point and run the point checks
        logic mul_step;  // one step of the lateral-acceleration multiply
        logic div_start; // prepare the jerk division
        logic div_step;  // one quotient bit
        logic finish;    // commit pair results and history
        logic clear;     // end of trajectory: clear track state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic checked;   // loaded point is within the horizon
        logic need_pair; // a pair check is needed for the loaded point
        logic dt_zero;   // time step is zero
        logic last;      // loaded point is the last one
    } t_status;

endpackage

@@ rtl/tlc_datapath.sv @@
// Datapath of the trajectory limit checker: registers, bound checks, divider and multiplier.
module tlc_datapath #(
    parameter int unsigned TOL = 1,
    parameter int signed CURV_MIN = -13107,
    parameter int signed CURV_MAX = 13107,
    parameter int signed LAT_MIN = -262144
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlc_pkg::t_cmd     i_cmd,
    output tlc_pkg::t_status  o_status,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic [31:0]       i_time,
    input  logic [31:0]       i_speed,
    input  logic [31:0]       i_accel,
    input  logic [31:0]       i_curv,
    input  logic              i_last,
    output logic [2:0]        o_verdict
);
    import tlc_pkg::*;

    logic [30:0]        r_horizon;
    logic signed [31:0] r_speed_min, r_speed_max, r_accel_min, r_accel_max;
    logic signed [31:0] r_jerk_min, r_jerk_max, r_lat_max;

    logic signed [31:0] r_t, r_a;
    logic               r_last;
    logic signed [31:0] r_prev_t, r_prev_a;
    logic               r_have_prev, r_past;
    t_verdict           r_bound_err, r_pair_err;
    logic               r_checked;

    // Divider state: restoring, one quotient bit per step.
    logic [48:0]        r_rem;
    logic [48:0]        r_dividend;
    logic [32:0]        r_divisor;
    logic [48:0]        r_quot;
    logic               r_qneg;

    // Lateral multiply: m = floor(floor(v*v/2^16)*|k|/2^16), serial over v2 bits.
    // The accumulator holds the full product v2*|k| before it is reduced.
    logic [46:0]        r_v2;
    logic [31:0]        r_ak;
    logic [77:0]        r_macc;
    logic               r_kneg;

    function automatic logic in_rng(input logic signed [33:0] v,
                                    input logic signed [33:0] lo,
                                    input logic signed [33:0] hi);
        in_rng = (v > lo - 34'sd1 * $signed({1'b0, TOL[16:0]})) &&
                 (v < hi + 34'sd1 * $signed({1'b0, TOL[16:0]}));
    endfunction

    // Point checks on incoming data.
    logic        n_past;
    t_verdict    n_bound;
    logic [31:0] abs_v;
    logic [31:0] abs_k;
    always_comb begin
        n_past  = r_past ||
                  ($signed({i_time[31], i_time}) > $signed({2'b0, r_horizon}));
        n_bound = r_bound_err;
        if (!n_past && r_bound_err == V_VALID) begin
            if (!in_rng(34'(signed'(i_speed)), 34'(r_speed_min), 34'(r_speed_max)))
                n_bound = V_SPEED;
            else if (!in_rng(34'(signed'(i_accel)), 34'(r_accel_min), 34'(r_accel_max)))
                n_bound = V_ACCEL;
            else if (!in_rng(34'(signed'(i_curv)), 34'(CURV_MIN), 34'(CURV_MAX)))
                n_bound = V_CURV;
        end
        abs_v = i_speed[31] ? 32'(-i_speed) : i_speed;
        abs_k = i_curv[31] ? 32'(-i_curv) : i_curv;
    end

    // Time step and accel difference.
    logic signed [32:0] dt;
    logic signed [32:0] da;
    always_comb begin
        dt = 33'(r_t) - 33'(r_prev_t);
        da = 33'(r_a) - 33'(r_prev_a);
    end

    logic [48:0] trial;
    logic [48:0] rem_sh;
    always_comb begin
        rem_sh = {r_rem[47:0], r_dividend[48]};
        trial  = rem_sh - {16'b0, r_divisor};
    end

    // Jerk saturation and lateral result.
    logic signed [31:0] jerk;
    logic signed [31:0] lat;
    logic [31:0]        lat_mag;
    always_comb begin
        if (r_quot > 49'd2147483647 && !r_qneg)      jerk = 32'sh7FFFFFFF;
        else if (r_quot > 49'd2147483648 && r_qneg)  jerk = 32'sh80000000;
        else if (r_qneg)                             jerk = 32'(-r_quot[31:0]);
        else                                         jerk = r_quot[31:0];
        lat_mag = (r_macc > 78'd2147483648) ? 32'h80000000 : r_macc[31:0];
        lat     = r_kneg ? 32'(-lat_mag) : lat_mag;
        if (!r_kneg && lat_mag[31]) lat = 32'sh7FFFFFFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon   <= 31'd524288;
            r_speed_min <= 32'sd0;
            r_speed_max <= 32'sd1310720;
            r_accel_min <= -32'sd393216;
            r_accel_max <= 32'sd262144;
            r_jerk_min  <= -32'sd262144;
            r_jerk_max  <= 32'sd262144;
            r_lat_max   <= 32'sd262144;
            r_prev_t    <= '0;
            r_prev_a    <= '0;
            r_have_prev <= 1'b0;
            r_past      <= 1'b0;
            r_bound_err <= V_VALID;
            r_pair_err  <= V_VALID;
            r_checked   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HORIZON:   r_horizon   <= i_cfg_data[30:0];
                    REG_SPEED_MIN: r_speed_min <= i_cfg_data;
                    REG_SPEED_MAX: r_speed_max <= i_cfg_data;
                    REG_ACCEL_MIN: r_accel_min <= i_cfg_data;
                    REG_ACCEL_MAX: r_accel_max <= i_cfg_data;
                    REG_JERK_MIN:  r_jerk_min  <= i_cfg_data;
                    REG_JERK_MAX:  r_jerk_max  <= i_cfg_data;
                    REG_LAT_MAX:   r_lat_max   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_past      <= n_past;
                r_bound_err <= n_bound;
                r_checked   <= !n_past;
            end
            if (i_cmd.finish) begin
                if (r_checked) begin
                    if (r_have_prev && r_pair_err == V_VALID) begin
                        if (dt == 33'sd0) r_pair_err <= V_JERK;
                        else if (!in_rng(34'(jerk), 34'(r_jerk_min), 34'(r_jerk_max)))
                            r_pair_err <= V_JERK;
                        else if (!in_rng(34'(lat), 34'(LAT_MIN), 34'(r_lat_max)))
                            r_pair_err <= V_LAT;
                    end
                    r_prev_t    <= r_t;
                    r_prev_a    <= r_a;
                    r_have_prev <= 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_prev_t    <= '0;
                r_prev_a    <= '0;
                r_have_prev <= 1'b0;
                r_past      <= 1'b0;
                r_bound_err <= V_VALID;
                r_pair_err  <= V_VALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t    <= i_time;
            r_a    <= i_accel;
            r_last <= i_last;
            r_v2   <= 47'(({32'b0, abs_v} * {32'b0, abs_v}) >> 16);
            r_ak   <= abs_k;
            r_kneg <= i_curv[31];
            r_macc <= '0;
        end
        if (i_cmd.mul_step) begin
            // Shift-add over the bits of v2, high bit first.
            r_v2   <= {r_v2[45:0], 1'b0};
            r_macc <= {r_macc[76:0], 1'b0} + (r_v2[46] ? 78'(r_ak) : 78'd0);
        end
        if (i_cmd.div_start) begin
            r_qneg     <= da[32] ^ dt[32];
            r_dividend <= {(da[32] ? 33'(-da) : 33'(da)), 16'b0};
            r_divisor  <= dt[32] ? 33'(-dt) : 33'(dt);
            r_rem      <= '0;
            r_quot     <= '0;
            // Reduce the full product to the floored form.
            r_macc     <= r_macc >> 16;
        end
        if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[47:0], 1'b0};
            if (!trial[48]) begin
                r_rem  <= trial;
                r_quot <= {r_quot[47:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_quot <= {r_quot[47:0], 1'b0};
            end
        end
    end

    assign o_status.checked   = r_checked;
    assign o_status.need_pair = r_checked && r_have_prev && (r_pair_err == V_VALID);
    assign o_status.dt_zero   = (dt == 33'sd0);
    assign o_status.last      = r_last;
    assign o_verdict = (r_bound_err != V_VALID) ? r_bound_err : r_pair_err;
endmodule

@@ rtl/tlc_ctrl.sv @@
// Controller state machine of the trajectory limit checker.
module tlc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tlc_pkg::t_status i_status,
    output tlc_pkg::t_cmd    o_cmd
);
    import tlc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       acc;

    assign acc         = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: if (acc) begin
                o_cmd.load = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.need_pair && !i_status.dt_zero) begin
                    n_state = S_MUL;
                    n_cnt   = 6'd0;
                end else n_state = S_FIN;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 6'd1;
                if (r_cnt == 6'd46) begin
                    n_state = S_DIV;
                    n_cnt   = 6'd0;
                end
            end
            S_DIV: begin
                if (r_cnt == 6'd0) o_cmd.div_start = 1'b1;
                else               o_cmd.div_step  = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd49) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = i_status.last ? S_OUT : S_IDLE;
            end
            S_OUT: if (i_out_ready) begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

@@ rtl/trajectory_limit_checker_unit.sv @@
// Top level of the trajectory limit checker.
// Usage:
// Points arrive on the input channel (i_in_valid / o_in_ready), one transaction
// per point, with signed Q16.16 time, speed, acceleration and curvature and a
// last flag. Only a last point produces an output transaction carrying a
// 3-bit verdict (o_out_valid / i_out_ready). Configuration registers are
// written through i_cfg_we, i_cfg_index and i_cfg_data while the block is idle.
// A point without a pair check, or with a zero time step, goes from evaluation
// straight to finish; a point with a full pair check also runs the bit-serial
// lateral multiply (47 steps) and the restoring jerk divider (one setup step and
// 49 quotient bits). No new point is taken until the current one is finished.
// The verdict appears in the cycle after the last point finishes and holds while
// the receiver stalls; no new point is taken until it is delivered.
// A synchronous active-low reset restores register defaults and clears the
// trajectory state.
module trajectory_limit_checker_unit #(
    parameter int unsigned TOLERANCE = 1,
    parameter int signed CURVATURE_MIN = -13107,
    parameter int signed CURVATURE_MAX = 13107,
    parameter int signed LATERAL_ACCEL_MIN = -262144
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_point_time,
    input  logic [31:0] i_point_speed,
    input  logic [31:0] i_point_accel,
    input  logic [31:0] i_point_curvature,
    input  logic        i_last_point,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_verdict,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tlc_pkg::*;

    t_cmd    cmd;
    t_status status;

    tlc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(status), .o_cmd(cmd)
    );

    tlc_datapath #(
        .TOL(TOLERANCE), .CURV_MIN(CURVATURE_MIN), .CURV_MAX(CURVATURE_MAX),
        .LAT_MIN(LATERAL_ACCEL_MIN)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_cfg_we, .i_cfg_idx(i_cfg_index), .i_cfg_data,
        .i_time(i_point_time), .i_speed(i_point_speed), .i_accel(i_point_accel),
        .i_curv(i_point_curvature), .i_last(i_last_point), .o_verdict
    );

`ifndef SYNTHESIS
    // No point may be accepted while a verdict waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken during output");
    // A stalled verdict holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict))
        else $error("verdict changed while stalled");
`endif
endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the trajectory limit checker with random idling and stalls.
module testbench;
    import tlc_pkg::*;

    localparam longint TOL      = 1;
    localparam longint CURV_MIN = -13107;
    localparam longint CURV_MAX = 13107;
    localparam longint LAT_MIN  = -262144;

    // One trajectory point as it travels on the input channel.
    typedef struct {
        logic [31:0] t;
        logic [31:0] v;
        logic [31:0] a;
        logic [31:0] k;
        logic        last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_point_time = '0;
    logic [31:0] i_point_speed = '0;
    logic [31:0] i_point_accel = '0;
    logic [31:0] i_point_curvature = '0;
    logic        i_last_point = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_verdict;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    trajectory_limit_checker_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_point_time(i_point_time), .i_point_speed(i_point_speed),
        .i_point_accel(i_point_accel), .i_point_curvature(i_point_curvature),
        .i_last_point(i_last_point),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_verdict(o_verdict),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    longint horizon, spd_lo, spd_hi, acc_lo, acc_hi, jrk_lo, jrk_hi, lat_hi;

    // Shadow copy of the per-trajectory tracking state.
    longint   prev_time, prev_accel;
    bit       have_prev, past_horizon;
    t_verdict bound_err, pair_err;

    t_point   pending_points[$];
    t_verdict expected_verdicts[$];
    int       mismatches = 0;

    function automatic longint sx32(logic [31:0] x);
        return longint'(signed'(x));
    endfunction

    function automatic bit within_bounds(longint x, longint lo, longint hi);
        return (x > lo - TOL) && (x < hi + TOL);
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Lateral acceleration v*v*kappa in Q16.16, truncated the same way as the hardware.
    function automatic longint lateral_accel(longint v, longint k);
        longint unsigned av, ak, v2, vh, vl, m;
        longint r;
        av = (v < 0) ? -v : v;
        ak = (k < 0) ? -k : k;
        v2 = (av * av) >> 16;
        vh = v2 >> 16;
        vl = v2 & 64'hFFFF;
        m  = vh * ak + ((vl * ak) >> 16);
        if (m > 64'd2147483648) m = 64'd2147483648;
        r = longint'(m);
        if (k < 0) r = -r;
        return sat32(r);
    endfunction

    function automatic void clear_track();
        prev_time    = 0;
        prev_accel   = 0;
        have_prev    = 1'b0;
        past_horizon = 1'b0;
        bound_err    = V_VALID;
        pair_err     = V_VALID;
    endfunction

    // Advances the tracking state by one accepted point and queues a verdict on a last point.
    function automatic void track_point(t_point p);
        longint t, v, a, k, dt, jerk;
        t = sx32(p.t);
        v = sx32(p.v);
        a = sx32(p.a);
        k = sx32(p.k);
        if (!past_horizon && t > horizon) past_horizon = 1'b1;
        if (!past_horizon) begin
            if (bound_err == V_VALID) begin
                if (!within_bounds(v, spd_lo, spd_hi)) bound_err = V_SPEED;
                else if (!within_bounds(a, acc_lo, acc_hi)) bound_err = V_ACCEL;
                else if (!within_bounds(k, CURV_MIN, CURV_MAX)) bound_err = V_CURV;
            end
            if (have_prev && pair_err == V_VALID) begin
                dt = t - prev_time;
                if (dt == 0) begin
                    pair_err = V_JERK;
                end else begin
                    jerk = sat32(((a - prev_accel) * 65536) / dt);
                    if (!within_bounds(jerk, jrk_lo, jrk_hi)) pair_err = V_JERK;
                    else if (!within_bounds(lateral_accel(v, k), LAT_MIN, lat_hi))
                        pair_err = V_LAT;
                end
            end
            prev_time  = t;
            prev_accel = a;
            have_prev  = 1'b1;
        end
        if (p.last) begin
            expected_verdicts.push_back((bound_err != V_VALID) ? bound_err : pair_err);
            clear_track();
        end
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Input driver: holds each transaction until it is accepted, then idles for a random gap.
    int        in_gap = 0;
    int        in_burst = 0;
    t_point    cur_point;
    bit        holding;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                cur_point.t    = i_point_time;
                cur_point.v    = i_point_speed;
                cur_point.a    = i_point_accel;
                cur_point.k    = i_point_curvature;
                cur_point.last = i_last_point;
                track_point(cur_point);
                holding = 1'b0;
            end
            if (!holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    cur_point = pending_points.pop_front();
                    i_point_time      <= cur_point.t;
                    i_point_speed     <= cur_point.v;
                    i_point_accel     <= cur_point.a;
                    i_point_curvature <= cur_point.k;
                    i_last_point      <= cur_point.last;
                    i_in_valid        <= 1'b1;
                    // Some stretches run back to back with no idling at all.
                    if (in_burst > 0) begin
                        in_burst--;
                        in_gap = 0;
                    end else begin
                        in_gap = pick_gap();
                        if ($urandom_range(0, 49) == 0) in_burst = $urandom_range(10, 40);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each verdict transaction with the oldest expected one.
    int out_stall = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: verdict %0d delivered with none expected", o_verdict);
                end else if (o_verdict !== expected_verdicts[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: verdict expected %0d, got %0d",
                                 expected_verdicts[0], o_verdict);
                    void'(expected_verdicts.pop_front());
                end else begin
                    void'(expected_verdicts.pop_front());
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                out_stall = pick_gap();
            end
        end
    end

    function automatic void push_point(longint t, longint v, longint a, longint k, bit last);
        t_point p;
        p.t    = t[31:0];
        p.v    = v[31:0];
        p.a    = a[31:0];
        p.k    = k[31:0];
        p.last = last;
        pending_points.push_back(p);
    endfunction

    function automatic logic [31:0] rand32();
        return $urandom();
    endfunction

    // A value near or inside [lo, hi], with edges and wild values mixed in.
    function automatic longint pick_value(longint lo, longint hi);
        int r;
        longint unsigned span;
        r = $urandom_range(0, 19);
        if (r == 0) return sx32(rand32());
        if (r == 1) return sat32(lo + $urandom_range(0, 2) - 1);
        if (r == 2) return sat32(hi + $urandom_range(0, 2) - 1);
        if (hi < lo) return sx32(rand32());
        span = longint'(hi - lo) + 1;
        return lo + longint'({$urandom(), $urandom()} % span);
    endfunction

    // One trajectory: mostly well formed, with some noise points and broken time steps.
    function automatic void push_trajectory();
        int     n;
        longint t, a, dt, j, k;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        t = ($urandom_range(0, 3) == 0) ? sx32(rand32()) >>> $urandom_range(0, 31) : 0;
        a = pick_value(acc_lo, acc_hi);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_point(sx32(rand32()), sx32(rand32()), sx32(rand32()), sx32(rand32()),
                           i == n - 1);
            end else begin
                k = pick_value(CURV_MIN, CURV_MAX) >>> $urandom_range(0, 12);
                push_point(t, pick_value(spd_lo, spd_hi), a, k, i == n - 1);
            end
            case ($urandom_range(0, 19))
                0:       dt = 0;
                1:       dt = -longint'($urandom_range(1, 70000));
                2:       dt = $urandom_range(1, 3);
                default: dt = $urandom_range(600, 20000);
            endcase
            t = sat32(t + dt);
            j = pick_value(jrk_lo, jrk_hi);
            if (dt != 0) a = sat32(a + (j * dt) / 65536);
        end
    endfunction

    // Register writes on consecutive edges, mirrored into the shadow copy.
    task automatic write_config(longint values[8]);
        for (int i = 0; i < 8; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= values[i][31:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        horizon = values[REG_HORIZON] & 64'h7FFF_FFFF;
        spd_lo  = sx32(values[REG_SPEED_MIN][31:0]);
        spd_hi  = sx32(values[REG_SPEED_MAX][31:0]);
        acc_lo  = sx32(values[REG_ACCEL_MIN][31:0]);
        acc_hi  = sx32(values[REG_ACCEL_MAX][31:0]);
        jrk_lo  = sx32(values[REG_JERK_MIN][31:0]);
        jrk_hi  = sx32(values[REG_JERK_MAX][31:0]);
        lat_hi  = sx32(values[REG_LAT_MAX][31:0]);
    endtask

    // Waits until every point is accepted and every verdict delivered, then lets the block settle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_points.size() != 0 || i_in_valid || expected_verdicts.size() != 0);
        repeat (200) @(posedge i_clk);
    endtask

    longint cfg[8];
    int     pushed;
    int     queued_prior;
    initial begin
        clear_track();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults written explicitly so the shadow copy starts in step with the block.
        cfg = '{524288, 0, 1310720, -393216, 262144, -262144, 262144, 262144};
        write_config(cfg);

        // Directed trajectories under the default bounds.
        push_point(0, 10 << 16, 0, 0, 1);                          // clean single point
        push_point(0, -64'sd2147483648, 0, 0, 1);                  // speed far below
        push_point(0, 10 << 16, 64'sd2147483647, 0, 1);            // accel far above
        push_point(0, 10 << 16, 0, CURV_MAX + 1, 1);               // curvature just out
        push_point(0, 0, -393216, CURV_MIN, 1);                    // all on the lower edges
        push_point(65536, 1 << 16, 0, 0, 0);                       // zero time step
        push_point(65536, 1 << 16, 0, 0, 1);
        push_point(131072, 1 << 16, 0, 0, 0);                      // decreasing time
        push_point(65536, 1 << 16, 65536, 0, 1);
        push_point(0, 1 << 16, 0, 0, 0);                           // past horizon not checked
        push_point(64'sd2147483647, -1, 64'sd2147483647, 64'sd2147483647, 0);
        push_point(0, -1, 0, 0, 1);
        push_point(0, 20 << 16, 0, 0, 0);                          // lateral too high
        push_point(6554, 20 << 16, 0, CURV_MAX, 1);
        push_point(0, 20 << 16, 0, 0, 0);                          // lateral too low
        push_point(6554, 20 << 16, 0, CURV_MIN, 1);
        push_point(0, 1 << 16, -393216, 0, 0);                     // jerk saturates
        push_point(1, 1 << 16, 262144, 0, 1);
        push_point(0, 1 << 16, 0, 0, 0);                           // bound error beats pair error
        push_point(0, 1 << 16, 0, 0, 0);
        push_point(65536, -64'sd2147483648, 0, 0, 1);
        push_point(-64'sd2147483648, 1 << 16, 0, 0, 0);            // most negative time
        push_point(-64'sd2147483647, 1 << 16, 0, 0, 1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: cfg = '{524288, 0, 1310720, -393216, 262144, -262144, 262144, 262144};
                1: cfg = '{64'hFFFF_FFFF, -64'sd2147483648, 64'sd2147483647,
                           -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                           64'sd2147483647, 64'sd2147483647};
                2: cfg = '{0, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                           -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                           -64'sd2147483648};
                3: cfg = '{rand32(), sx32(rand32()), sx32(rand32()), sx32(rand32()),
                           sx32(rand32()), sx32(rand32()), sx32(rand32()), sx32(rand32())};
                default: begin
                    cfg[REG_HORIZON]   = $urandom_range(65536, 1 << 20);
                    cfg[REG_SPEED_MIN] = -longint'($urandom_range(0, 5 << 16));
                    cfg[REG_SPEED_MAX] = $urandom_range(5 << 16, 40 << 16);
                    cfg[REG_ACCEL_MIN] = -longint'($urandom_range(0, 8 << 16));
                    cfg[REG_ACCEL_MAX] = $urandom_range(0, 8 << 16);
                    cfg[REG_JERK_MIN]  = -longint'($urandom_range(0, 8 << 16));
                    cfg[REG_JERK_MAX]  = $urandom_range(0, 8 << 16);
                    cfg[REG_LAT_MAX]   = $urandom_range(0, 8 << 16);
                end
            endcase
            write_config(cfg);
            // About 215 points per phase, in whole trajectories.
            pushed = 0;
            while (pushed < 215) begin
                queued_prior = pending_points.size();
                push_trajectory();
                pushed = pushed + pending_points.size() - queued_prior;
                while (pending_points.size() > 40) @(posedge i_clk);
            end
            drain();
        end

        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #30000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
